[hw/rtl/sprite_frame_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// sprite frame sequencer assertion macros
// shared property forms for the sequencer checks
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SFS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprite frame sequencer check failed");

// next-cycle implication
`define SFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprite frame sequencer check failed");

`endif

[hw/rtl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// types and constants shared by the sprite frame sequencer modules
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int FRAME_W    = 12;
   localparam int PERIOD_W   = 20;
   localparam int ACC_W      = 24;
   localparam int FPR_W      = 7;
   localparam int BLK_W      = 11;
   localparam int TEX_W      = 16;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int DIV_CNT_W  = $clog2(FRAME_W);
   localparam int PROD_W     = FRAME_W + BLK_W;

   localparam int ANIM_BACK     = 0;
   localparam int ANIM_LOOP     = 1;
   localparam int ANIM_PINGPONG = 2;

   typedef enum logic [MODE_W-1:0] {
      CMD_TICK    = 3'd0,
      CMD_PLAY    = 3'd1,
      CMD_PAUSE   = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_RESTART = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_PERIOD   = 3'd0,
      REG_ANIM_MODE      = 3'd1,
      REG_START_FRAME    = 3'd2,
      REG_END_FRAME      = 3'd3,
      REG_FRAMES_PER_ROW = 3'd4,
      REG_BLOCK_WIDTH    = 3'd5,
      REG_BLOCK_HEIGHT   = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] frame_period;
      logic [2:0]          anim_mode;
      logic [FRAME_W-1:0]  start_frame;
      logic [FRAME_W-1:0]  end_frame;
      logic [FPR_W-1:0]    frames_per_row;
      logic [BLK_W-1:0]    block_width;
      logic [BLK_W-1:0]    block_height;
   } cfg_type;

   typedef struct packed {
      logic                exec;
      cmd_type             mode;
      logic [PERIOD_W-1:0] elapsed;
   } op_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               running;
   } st_type;

   typedef struct packed {
      logic               done;
      logic [FRAME_W-1:0] quot;
      logic [FPR_W-1:0]   rem;
   } div_res_type;

endpackage

[hw/rtl/sprite_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// sprite sheet animation sequencer with texel origin of the current frame
// ----------------------------------------------------------------------------
// Each request (tick, play, pause, stop, restart) yields one response with the
// frame index, its texel origin on the sheet and the playing flag. A request
// takes these steps from acceptance to a loaded response: apply the command,
// compare the time against the frame period and step, load the divider, run
// the serial divide of the frame by frames per row (12 quotient bits at one
// bit per cycle, then the done flag), form the x and then the y origin on one
// shared multiplier and load the output register. req_ready is high only while
// the sequencer is idle; it returns as soon as the response is in the output
// register, so a new request is taken only once the last response is loaded,
// which waits while an earlier response holds the output register.
// Configuration writes are taken in any cycle.
`include "sprite_frame_sequencer_defines.svh"

module sprite_frame_sequencer
   import sfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [PERIOD_W-1:0]   req_elapsed_us,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FRAME_W-1:0]    rsp_frame_index,
   output logic [TEX_W-1:0]      rsp_tex_x,
   output logic [TEX_W-1:0]      rsp_tex_y,
   output logic                  rsp_playing,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_STEP,
      S_DSTART,
      S_DWAIT,
      S_MULX,
      S_MULY,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   cfg_type cfg_ff;

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic [TEX_W-1:0]    tex_x_ff, tex_x_in;
   logic [TEX_W-1:0]    tex_y_ff, tex_y_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [TEX_W-1:0]    rsp_x_ff, rsp_x_in;
   logic [TEX_W-1:0]    rsp_y_ff, rsp_y_in;
   logic                rsp_play_ff, rsp_play_in;

   op_type      op;
   st_type      st;
   div_res_type div_res;

   logic [FRAME_W-1:0] mul_a;
   logic [BLK_W-1:0]   mul_b;
   logic [PROD_W-1:0]  product;
   logic               req_fire;
   logic               slot_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_period   <= PERIOD_W'(100000);
         cfg_ff.anim_mode      <= '0;
         cfg_ff.start_frame    <= '0;
         cfg_ff.end_frame      <= '0;
         cfg_ff.frames_per_row <= FPR_W'(1);
         cfg_ff.block_width    <= BLK_W'(1);
         cfg_ff.block_height   <= BLK_W'(1);
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_FRAME_PERIOD:   cfg_ff.frame_period   <= csr_data;
            REG_ANIM_MODE:      cfg_ff.anim_mode      <= csr_data[2:0];
            REG_START_FRAME:    cfg_ff.start_frame    <= csr_data[FRAME_W-1:0];
            REG_END_FRAME:      cfg_ff.end_frame      <= csr_data[FRAME_W-1:0];
            REG_FRAMES_PER_ROW: cfg_ff.frames_per_row <= csr_data[FPR_W-1:0];
            REG_BLOCK_WIDTH:    cfg_ff.block_width    <= csr_data[BLK_W-1:0];
            REG_BLOCK_HEIGHT:   cfg_ff.block_height   <= csr_data[BLK_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign op.exec    = (state_ff == S_EXEC);
   assign op.mode    = cmd_type'(mode_ff);
   assign op.elapsed = elapsed_ff;

   sfs_state u_state (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .op    (op),
      .st    (st)
   );

   sfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DSTART),
      .dividend (st.frame),
      .divisor  (cfg_ff.frames_per_row),
      .res      (div_res)
   );

   // shared multiplier for column and row origins
   assign mul_a   = (state_ff == S_MULX) ? FRAME_W'(div_res.rem) : div_res.quot;
   assign mul_b   = (state_ff == S_MULX) ? cfg_ff.block_width : cfg_ff.block_height;
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      elapsed_in   = elapsed_ff;
      tex_x_in     = tex_x_ff;
      tex_y_in     = tex_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_play_in  = rsp_play_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in    = req_mode;
               elapsed_in = req_elapsed_us;
               state_in   = S_EXEC;
            end
         end
         S_EXEC:   state_in = S_STEP;
         S_STEP:   state_in = S_DSTART;
         S_DSTART: state_in = S_DWAIT;
         S_DWAIT: begin
            if (div_res.done) begin
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            tex_x_in = product[TEX_W-1:0];
            state_in = S_MULY;
         end
         S_MULY: begin
            tex_y_in = product[TEX_W-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = st.frame;
               rsp_x_in     = tex_x_ff;
               rsp_y_in     = tex_y_ff;
               rsp_play_in  = st.running;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      elapsed_ff   <= elapsed_in;
      tex_x_ff     <= tex_x_in;
      tex_y_ff     <= tex_y_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_play_ff  <= rsp_play_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_index = rsp_frame_ff;
   assign rsp_tex_x       = rsp_x_ff;
   assign rsp_tex_y       = rsp_y_ff;
   assign rsp_playing     = rsp_play_ff;

   `SFS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready)
   `SFS_ASSERT_NOW(a_div_done_before_mul, clock, reset, state_ff == S_MULX, div_res.done)
   `SFS_ASSERT_NEXT(a_out_loads_rsp, clock, reset, (state_ff == S_OUT) && slot_free, rsp_valid)

endmodule

[hw/rtl/sfs_state.sv]
// ----------------------------------------------------------------------------
// sfs_state
// animation state: command decode, time accumulator and frame stepping
// ----------------------------------------------------------------------------
module sfs_state
   import sfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  op_type  op,
   output st_type  st
);

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               back_ff, back_in;
   logic               run_ff, run_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               pend_ff, pend_in;

   logic [ACC_W:0]           sum;
   logic [ACC_W-1:0]         acc_sat;
   logic signed [FRAME_W+1:0] f_step, s_ext, e_ext, f_new;
   logic                      past_end, past_start;
   logic                      back_new, run_new;
   logic                      m_back, m_loop, m_pp;

   assign m_back = cfg.anim_mode[ANIM_BACK];
   assign m_loop = cfg.anim_mode[ANIM_LOOP];
   assign m_pp   = cfg.anim_mode[ANIM_PINGPONG];

   assign sum     = {1'b0, acc_ff} + (ACC_W+1)'(op.elapsed);
   assign acc_sat = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

   assign f_step = $signed({2'b00, frame_ff}) + (back_ff ? -(FRAME_W+2)'(1) : (FRAME_W+2)'(1));
   assign s_ext  = $signed({2'b00, cfg.start_frame});
   assign e_ext  = $signed({2'b00, cfg.end_frame});
   assign past_end   = f_step > e_ext;
   assign past_start = f_step < s_ext;

   // end of range rules
   always_comb begin
      f_new    = f_step;
      back_new = back_ff;
      run_new  = run_ff;
      if (m_pp && m_loop) begin
         if (past_end) begin
            f_new    = e_ext;
            back_new = !back_ff;
         end else if (past_start) begin
            f_new    = s_ext;
            back_new = !back_ff;
         end
      end else if (m_pp && !m_back) begin
         if (past_end) begin
            f_new    = e_ext;
            back_new = !back_ff;
         end else if (past_start) begin
            f_new   = s_ext;
            run_new = 1'b0;
         end
      end else if (m_pp) begin
         if (past_start) begin
            f_new    = s_ext;
            back_new = !back_ff;
         end else if (past_end) begin
            f_new   = e_ext;
            run_new = 1'b0;
         end
      end else if (m_loop && !m_back) begin
         if (past_end) begin
            f_new = s_ext;
         end
      end else if (m_loop) begin
         if (past_start) begin
            f_new = e_ext;
         end
      end else if (!m_back) begin
         if (past_end) begin
            f_new   = e_ext;
            run_new = 1'b0;
         end
      end else begin
         if (past_start) begin
            f_new   = s_ext;
            run_new = 1'b0;
         end
      end
   end

   always_comb begin
      frame_in = frame_ff;
      back_in  = back_ff;
      run_in   = run_ff;
      acc_in   = acc_ff;
      pend_in  = 1'b0;
      if (op.exec) begin
         case (op.mode)
            CMD_TICK: begin
               if (run_ff) begin
                  acc_in  = acc_sat;
                  pend_in = 1'b1;
               end
            end
            CMD_PLAY:  run_in = 1'b1;
            CMD_PAUSE: run_in = 1'b0;
            CMD_STOP: begin
               run_in   = 1'b0;
               frame_in = cfg.start_frame;
            end
            CMD_RESTART: begin
               back_in  = m_back;
               frame_in = m_back ? cfg.end_frame : cfg.start_frame;
               acc_in   = '0;
            end
            default: ;
         endcase
      end else if (pend_ff) begin
         if (acc_ff >= ACC_W'(cfg.frame_period)) begin
            frame_in = f_new[FRAME_W-1:0];
            back_in  = back_new;
            run_in   = run_new;
            acc_in   = acc_ff - ACC_W'(cfg.frame_period);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         back_ff  <= 1'b0;
         run_ff   <= 1'b0;
         acc_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         back_ff  <= back_in;
         run_ff   <= run_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
      end
   end

   assign st.frame   = frame_ff;
   assign st.running = run_ff;

endmodule

[hw/rtl/sfs_div.sv]
// ----------------------------------------------------------------------------
// sfs_div
// serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sfs_div
   import sfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [FRAME_W-1:0] dividend,
   input  logic [FPR_W-1:0]   divisor,
   output div_res_type        res
);

   logic [FRAME_W-1:0]   quot_ff, quot_in;
   logic [FPR_W-1:0]     rem_ff, rem_in;
   logic [FPR_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [FPR_W:0] trial, diff;
   logic           ge;

   assign trial = {rem_ff, quot_ff[FRAME_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = (divisor == '0) ? FPR_W'(1) : divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[FRAME_W-2:0], ge};
         rem_in  = ge ? diff[FPR_W-1:0] : trial[FPR_W-1:0];
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(FRAME_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
   assign res.rem  = rem_ff;

endmodule

[tb/sprite_frame_sequencer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_checker
// response predictor and scoreboard for the sprite frame sequencer
// ----------------------------------------------------------------------------
// Watches the request, response and register channels. It keeps its own copy
// of the registers and of the animation state (frame, direction, running flag,
// time accumulator). For every accepted request it predicts the frame, texel
// origin and playing flag. Every accepted response is compared field by field
// with the oldest prediction. The mismatch count and the number of responses
// still owed go to the testbench top.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_checker
   import sfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [PERIOD_W-1:0]   req_elapsed_us,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [FRAME_W-1:0]    rsp_frame_index,
   input  logic [TEX_W-1:0]      rsp_tex_x,
   input  logic [TEX_W-1:0]      rsp_tex_y,
   input  logic                  rsp_playing,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    responses_outstanding,
   output int                    responses_checked,
   output int                    frame_steps,
   output int                    range_ends
);

   localparam int MAX_FRAMES   = 1 << FRAME_W;
   localparam int RESET_PERIOD = 100000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [TEX_W-1:0]   tex_x;
      logic [TEX_W-1:0]   tex_y;
      logic               playing;
   } frame_view_type;

   cfg_type            settings;
   logic [FRAME_W-1:0] cur_frame;
   logic               backward;
   logic               running;
   logic [ACC_W-1:0]   elapsed_total;
   frame_view_type     predicted_views[$];
   frame_view_type     want_view;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   // applies one command to the animation state and returns the frame view
   function automatic frame_view_type predict_view(input logic [MODE_W-1:0]   code,
                                                   input logic [PERIOD_W-1:0] elapsed);
      logic [ACC_W:0] sum;
      int             f;
      int             raw;
      int             first;
      int             last;
      bit             past_end;
      bit             past_start;
      int             per_row;
      int             col_texels;
      int             row_texels;
      frame_view_type view;
      case (code)
         CMD_TICK: begin
            if (running) begin
               sum = elapsed_total + elapsed;
               elapsed_total = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
               if (elapsed_total >= settings.frame_period) begin
                  f = int'(cur_frame) + (backward ? -1 : 1);
                  raw = f;
                  first = int'(settings.start_frame);
                  last = int'(settings.end_frame);
                  past_end = f > last;
                  past_start = f < first;
                  if (settings.anim_mode[ANIM_PINGPONG]) begin
                     if (settings.anim_mode[ANIM_LOOP]) begin
                        if (past_end) begin
                           f = last;
                           backward = !backward;
                        end else if (past_start) begin
                           f = first;
                           backward = !backward;
                        end
                     end else if (settings.anim_mode[ANIM_BACK]) begin
                        if (past_start) begin
                           f = first;
                           backward = !backward;
                        end else if (past_end) begin
                           f = last;
                           running = 1'b0;
                        end
                     end else begin
                        if (past_end) begin
                           f = last;
                           backward = !backward;
                        end else if (past_start) begin
                           f = first;
                           running = 1'b0;
                        end
                     end
                  end else if (settings.anim_mode[ANIM_LOOP]) begin
                     if (settings.anim_mode[ANIM_BACK]) begin
                        if (past_start) f = last;
                     end else if (past_end) begin
                        f = first;
                     end
                  end else if (settings.anim_mode[ANIM_BACK]) begin
                     if (past_start) begin
                        f = first;
                        running = 1'b0;
                     end
                  end else if (past_end) begin
                     f = last;
                     running = 1'b0;
                  end
                  if (f != raw) range_ends++;
                  // steps off either end of the frame space wrap around
                  if (f < 0) f += MAX_FRAMES;
                  cur_frame = f[FRAME_W-1:0];
                  frame_steps++;
                  elapsed_total = elapsed_total - settings.frame_period;
               end
            end
         end
         CMD_PLAY: running = 1'b1;
         CMD_PAUSE: running = 1'b0;
         CMD_STOP: begin
            running = 1'b0;
            cur_frame = settings.start_frame;
         end
         CMD_RESTART: begin
            backward = settings.anim_mode[ANIM_BACK];
            cur_frame = backward ? settings.end_frame : settings.start_frame;
            elapsed_total = '0;
         end
         default: ;
      endcase
      // zero frames per row counts as one
      per_row = (settings.frames_per_row == '0) ? 1 : int'(settings.frames_per_row);
      col_texels = (int'(cur_frame) % per_row) * int'(settings.block_width);
      row_texels = (int'(cur_frame) / per_row) * int'(settings.block_height);
      view.frame = cur_frame;
      view.tex_x = col_texels[TEX_W-1:0];
      view.tex_y = row_texels[TEX_W-1:0];
      view.playing = running;
      return view;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         settings = '{frame_period: PERIOD_W'(RESET_PERIOD), anim_mode: '0,
                      start_frame: '0, end_frame: '0, frames_per_row: FPR_W'(1),
                      block_width: BLK_W'(1), block_height: BLK_W'(1)};
         cur_frame = '0;
         backward = 1'b0;
         running = 1'b0;
         elapsed_total = '0;
         predicted_views.delete();
         mismatch_count = 0;
         responses_checked = 0;
         frame_steps = 0;
         range_ends = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FRAME_PERIOD:   settings.frame_period = csr_data[PERIOD_W-1:0];
               REG_ANIM_MODE:      settings.anim_mode = csr_data[2:0];
               REG_START_FRAME:    settings.start_frame = csr_data[FRAME_W-1:0];
               REG_END_FRAME:      settings.end_frame = csr_data[FRAME_W-1:0];
               REG_FRAMES_PER_ROW: settings.frames_per_row = csr_data[FPR_W-1:0];
               REG_BLOCK_WIDTH:    settings.block_width = csr_data[BLK_W-1:0];
               REG_BLOCK_HEIGHT:   settings.block_height = csr_data[BLK_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_views.size() == 0) begin
               report_mismatch($sformatf("response frame %0d with no request outstanding",
                                         rsp_frame_index));
            end else begin
               want_view = predicted_views.pop_front();
               if (rsp_frame_index !== want_view.frame)
                  report_mismatch($sformatf("response %0d frame_index %0d, predicted %0d",
                                            responses_checked, rsp_frame_index,
                                            want_view.frame));
               if (rsp_tex_x !== want_view.tex_x)
                  report_mismatch($sformatf("response %0d tex_x %0d, predicted %0d",
                                            responses_checked, rsp_tex_x, want_view.tex_x));
               if (rsp_tex_y !== want_view.tex_y)
                  report_mismatch($sformatf("response %0d tex_y %0d, predicted %0d",
                                            responses_checked, rsp_tex_y, want_view.tex_y));
               if (rsp_playing !== want_view.playing)
                  report_mismatch($sformatf("response %0d playing %0b, predicted %0b",
                                            responses_checked, rsp_playing,
                                            want_view.playing));
               responses_checked++;
            end
         end
         if (req_valid && req_ready) begin
            predicted_views.push_back(predict_view(req_mode, req_elapsed_us));
         end
      end
      responses_outstanding = predicted_views.size();
   end

endmodule

[tb/tb_sprite_frame_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer
// self-checking testbench for the sprite frame sequencer
// ----------------------------------------------------------------------------
// Drives a short directed sequence (field extremes, every command, unknown
// codes, zero period, zero frames per row, frame wrap at both ends of the frame
// space), then random phases, one per register setting, that restart, play and
// tick through mostly small frame ranges in all eight animation modes. Phases rotate
// between no idling, a sluggish sender, a stalling receiver and both, and one
// phase holds the receiver off long enough to back the block up. The checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer;
   import sfs_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 11;
   localparam int FRAME_MAX       = (1 << FRAME_W) - 1;
   localparam int PERIOD_MAX      = (1 << PERIOD_W) - 1;
   localparam int FPR_MAX         = (1 << FPR_W) - 1;
   localparam int BLK_MAX         = (1 << BLK_W) - 1;
   localparam int ELAPSED_TOP     = 1000000;
   localparam int CMD_CODE_MAX    = (1 << MODE_W) - 1;
   localparam int ANIM_CODES      = 8;
   localparam int MAX_SPAN        = 6;
   localparam int RANDOM_PHASES   = 11;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int PRESSURE_PHASE  = 0;
   localparam int SATURATE_PHASE  = 8;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 40;
   // longest legal quiet stretch is the hold-off plus one response latency
   localparam int WATCHDOG_LIMIT  = 5000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode = '0;
   logic [PERIOD_W-1:0]   req_elapsed_us = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [FRAME_W-1:0]    rsp_frame_index;
   logic [TEX_W-1:0]      rsp_tex_x;
   logic [TEX_W-1:0]      rsp_tex_y;
   logic                  rsp_playing;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int mismatch_count;
   int responses_outstanding;
   int responses_checked;
   int frame_steps;
   int range_ends;

   int   req_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   int   requests_sent = 0;
   int   settings_applied = 0;

   sprite_frame_sequencer u_dut (.*);

   sprite_frame_sequencer_checker u_checker (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // response side: random stalls plus the long hold-off
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [2:0] anim_bits(input bit back, input bit loop, input bit pingpong);
      logic [2:0] bits;
      bits = '0;
      bits[ANIM_BACK] = back;
      bits[ANIM_LOOP] = loop;
      bits[ANIM_PINGPONG] = pingpong;
      return bits;
   endfunction

   task automatic send_request(input logic [MODE_W-1:0] code, input logic [PERIOD_W-1:0] elapsed);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= code;
      req_elapsed_us <= elapsed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic write_register(input csr_reg_type index, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type cfg);
      write_register(REG_FRAME_PERIOD, cfg.frame_period);
      write_register(REG_ANIM_MODE, CSR_DATA_W'(cfg.anim_mode));
      write_register(REG_START_FRAME, CSR_DATA_W'(cfg.start_frame));
      write_register(REG_END_FRAME, CSR_DATA_W'(cfg.end_frame));
      write_register(REG_FRAMES_PER_ROW, CSR_DATA_W'(cfg.frames_per_row));
      write_register(REG_BLOCK_WIDTH, CSR_DATA_W'(cfg.block_width));
      write_register(REG_BLOCK_HEIGHT, CSR_DATA_W'(cfg.block_height));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // stop offering and let every owed response come back
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (responses_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                  phase;
      int                  r;
      int                  base;
      int                  span_top;
      bit                  heavy;
      cfg_type             cfg;
      logic [MODE_W-1:0]   code;
      logic [PERIOD_W-1:0] elapsed;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: single frame range, long period
      send_request(CMD_TICK, '0);
      send_request(CMD_PLAY, PERIOD_W'(ELAPSED_TOP));
      send_request(CMD_TICK, PERIOD_W'(PERIOD_MAX));
      send_request(MODE_W'(CMD_CODE_MAX), PERIOD_W'(PERIOD_MAX));
      send_request(CMD_PAUSE, '0);
      send_request(CMD_STOP, '0);
      send_request(CMD_RESTART, '0);

      // full range backward loop, zero period, zero frames per row
      wait_for_idle();
      apply_settings('{frame_period: '0, anim_mode: anim_bits(1, 1, 0), start_frame: '0,
                       end_frame: FRAME_W'(FRAME_MAX), frames_per_row: '0,
                       block_width: BLK_W'(BLK_MAX), block_height: BLK_W'(BLK_MAX)});
      send_request(CMD_RESTART, '0);
      send_request(CMD_PLAY, '0);
      send_request(CMD_TICK, PERIOD_W'(ELAPSED_TOP));
      send_request(CMD_TICK, '0);
      send_request(MODE_W'(CMD_RESTART + 1), PERIOD_W'(ELAPSED_TOP));

      // forward loop while still stepping backward: frame 0 wraps to the top
      wait_for_idle();
      apply_settings('{frame_period: '0, anim_mode: anim_bits(0, 1, 0), start_frame: '0,
                       end_frame: FRAME_W'(FRAME_MAX), frames_per_row: FPR_W'(64),
                       block_width: BLK_W'(1024), block_height: BLK_W'(1)});
      send_request(CMD_STOP, '0);
      send_request(CMD_PLAY, '0);
      send_request(CMD_TICK, PERIOD_W'(7));

      // restart forward at the top frame
      wait_for_idle();
      apply_settings('{frame_period: PERIOD_W'(1), anim_mode: anim_bits(0, 0, 0),
                       start_frame: FRAME_W'(FRAME_MAX), end_frame: FRAME_W'(FRAME_MAX),
                       frames_per_row: FPR_W'(FPR_MAX), block_width: '0,
                       block_height: '0});
      send_request(CMD_RESTART, PERIOD_W'(PERIOD_MAX));

      // backward mode while stepping forward: the top frame wraps to zero
      wait_for_idle();
      apply_settings('{frame_period: PERIOD_W'(1), anim_mode: anim_bits(1, 0, 0),
                       start_frame: FRAME_W'(FRAME_MAX), end_frame: FRAME_W'(FRAME_MAX),
                       frames_per_row: FPR_W'(FPR_MAX), block_width: BLK_W'(BLK_MAX),
                       block_height: BLK_W'(1)});
      send_request(CMD_TICK, PERIOD_W'(1));
      send_request(MODE_W'(CMD_RESTART + 2), '0);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         heavy = (phase == SATURATE_PHASE);
         cfg.anim_mode = (phase < ANIM_CODES) ? phase[2:0] : 3'($urandom_range(ANIM_CODES - 1));
         r = $urandom_range(99);
         if (heavy || r < 20) cfg.frame_period = '0;
         else if (r < 70) cfg.frame_period = PERIOD_W'($urandom_range(1, 64));
         else if (r < 90) cfg.frame_period = PERIOD_W'($urandom_range(65, 5000));
         else cfg.frame_period = PERIOD_W'($urandom_range(5001, PERIOD_MAX));
         // accumulator saturation: zero period, forward loop, big ticks only
         if (heavy) cfg.anim_mode = anim_bits(0, 1, 0);
         r = $urandom_range(99);
         if (r < 75) begin
            base = $urandom_range(0, FRAME_MAX - MAX_SPAN);
            cfg.start_frame = FRAME_W'(base);
            cfg.end_frame = FRAME_W'(base + $urandom_range(0, MAX_SPAN));
         end else if (r < 85) begin
            cfg.start_frame = FRAME_W'($urandom_range(0, FRAME_MAX));
            cfg.end_frame = FRAME_W'($urandom_range(0, FRAME_MAX));
         end else if (r < 93) begin
            cfg.start_frame = '0;
            cfg.end_frame = FRAME_W'($urandom_range(0, MAX_SPAN));
         end else begin
            cfg.start_frame = FRAME_W'(FRAME_MAX - $urandom_range(0, MAX_SPAN));
            cfg.end_frame = FRAME_W'(FRAME_MAX);
         end
         cfg.frames_per_row = FPR_W'(($urandom_range(9) == 0) ? $urandom_range(0, FPR_MAX)
                                                               : $urandom_range(1, 64));
         cfg.block_width = BLK_W'(($urandom_range(9) == 0) ? $urandom_range(0, BLK_MAX)
                                                           : $urandom_range(1, 1024));
         cfg.block_height = BLK_W'(($urandom_range(9) == 0) ? $urandom_range(0, BLK_MAX)
                                                            : $urandom_range(1, 1024));
         wait_for_idle();
         apply_settings(cfg);
         case (phase % 4)
            0: begin
               req_idle_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               req_idle_pct = 61;
               rsp_stall_pct <= 0;
            end
            2: begin
               req_idle_pct = 0;
               rsp_stall_pct <= 61;
            end
            default: begin
               req_idle_pct = 31;
               rsp_stall_pct <= 31;
            end
         endcase
         if (phase == PRESSURE_PHASE) hold_toggle <= !hold_toggle;
         send_request(CMD_RESTART, PERIOD_W'($urandom_range(0, PERIOD_MAX)));
         send_request(CMD_PLAY, PERIOD_W'($urandom_range(0, PERIOD_MAX)));
         repeat (ITEMS_PER_PHASE - 2) begin
            r = $urandom_range(99);
            if (heavy || r < 72) code = CMD_TICK;
            else if (r < 82) code = CMD_PLAY;
            else if (r < 87) code = CMD_PAUSE;
            else if (r < 91) code = CMD_STOP;
            else if (r < 97) code = CMD_RESTART;
            else code = MODE_W'($urandom_range(CMD_RESTART + 1, CMD_CODE_MAX));
            r = $urandom_range(99);
            if (heavy) begin
               elapsed = PERIOD_W'($urandom_range(800000, PERIOD_MAX));
            end else if (r < 80) begin
               span_top = 2 * int'(cfg.frame_period) + 2;
               if (span_top > PERIOD_MAX) span_top = PERIOD_MAX;
               elapsed = PERIOD_W'($urandom_range(0, span_top));
            end else if (r < 95) begin
               elapsed = PERIOD_W'($urandom_range(0, ELAPSED_TOP));
            end else if (r < 97) begin
               elapsed = '0;
            end else begin
               elapsed = PERIOD_W'(PERIOD_MAX);
            end
            send_request(code, elapsed);
         end
      end

      wait_for_idle();
      $display("covered %0d requests over %0d register settings and all eight animation modes",
               requests_sent, settings_applied);
      $display("%0d responses compared, %0d frame steps, %0d of them at a range end",
               responses_checked, frame_steps, range_ends);
      if (mismatch_count == 0 && responses_outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
